// File: rtl/core/rog_pkg.sv
// shared constants for the radius of gyration block
// result field widths and output beat layout; no dependencies
package rog_pkg;

    // result field widths
    localparam int RADIUS_W   = 16;
    localparam int POINTS_W   = 13;
    localparam int OUT_DATA_W = 32;

    // zero fill above the overflow flag in the output beat
    localparam int OUT_PAD_W  = OUT_DATA_W - RADIUS_W - POINTS_W - 1;

endpackage

// File: rtl/core/rog_mul.sv
// sequential shift-and-add unsigned multiplier, one multiplier bit per cycle
// shared by the variance and square-root search steps; no package dependency
module rog_mul #(
    parameter int MA = 45,
    parameter int MB = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MA-1:0]    a,
    input  logic [MB-1:0]    b,
    output logic             done,
    output logic [MA+MB-1:0] product
);

    localparam int CNT_W = $clog2(MB + 1);

    logic [MA-1:0]    hi_reg, hi_next;
    logic [MB-1:0]    lo_reg, lo_next;
    logic [MA-1:0]    a_reg, a_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MA:0]      partial;

    // conditional add of the multiplicand into the upper half
    assign partial = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(MA + 1){1'b0}});

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = b;
            a_next    = a;
            cnt_next  = CNT_W'(MB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the partial product right by one
            hi_next  = partial[MA:1];
            lo_next  = {partial[0], lo_reg[MB-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// File: rtl/core/radius_of_gyration_2d.sv
// radius of gyration of a 2d path: per-point accumulation, then an exact integer search
// after the last point the shared multiplier forms four variance products, then one square per
//   radius bit of the search; the multiplier handles one multiplier bit per cycle
// throughput: one point per cycle within a path; none taken during the search or while
//   a finished result waits for the output register; reset: rst_n async active low clears
//   accumulators, sequencer and output valid; depends on rog_pkg and rog_mul
module radius_of_gyration_2d
    import rog_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // x_coord, y_coord, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // last_point
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // gyration_radius, points_used, overflowed, zero fill
    output logic [OUT_DATA_W-1:0]                  m_axis_tdata
);

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SW    = COORD_BITS + CW;
    localparam int QW    = 2 * COORD_BITS + CW;
    localparam int RW    = COORD_BITS + 2;
    localparam int UW    = RW + CW;
    localparam int MA    = QW;
    localparam int MB    = UW;
    localparam int PW    = MA + MB;
    localparam int BIT_W = $clog2(RW);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_PROD_START = 3'd1;
    localparam logic [2:0] ST_PROD_WAIT  = 3'd2;
    localparam logic [2:0] ST_SQ_START   = 3'd3;
    localparam logic [2:0] ST_SQ_WAIT    = 3'd4;
    localparam logic [2:0] ST_OUT        = 3'd5;

    localparam logic [1:0] PS_XX = 2'd0;
    localparam logic [1:0] PS_YY = 2'd1;
    localparam logic [1:0] PS_SX = 2'd2;
    localparam logic [1:0] PS_SY = 2'd3;

    logic [2:0]             state_reg, state_next;
    logic [1:0]             prod_sel_reg, prod_sel_next;
    logic signed [SW-1:0]   sum_x_reg, sum_x_next;
    logic signed [SW-1:0]   sum_y_reg, sum_y_next;
    logic [QW-1:0]          sxx_reg, sxx_next;
    logic [QW-1:0]          syy_reg, syy_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   dropped_reg, dropped_next;
    logic [PW-1:0]          d_reg, d_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [UW-1:0]          rn_reg, rn_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic signed [COORD_BITS-1:0]   x_in, y_in;
    logic signed [2*COORD_BITS-1:0] x_sq_s, y_sq_s;
    logic [2*COORD_BITS-1:0]        x_sq, y_sq;
    logic                           in_fire;
    logic                           has_room;
    logic                           out_load;
    logic [SW-1:0]                  sx_mag, sy_mag;
    logic [UW-1:0]                  u_cand;
    logic                           mul_start, mul_done;
    logic [MA-1:0]                  mul_a;
    logic [MB-1:0]                  mul_b;
    logic [PW-1:0]                  mul_p;

    // input unpack and per-point squares
    assign x_in   = s_axis_tdata[COORD_BITS-1:0];
    assign y_in   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x_sq_s = x_in * x_in;
    assign y_sq_s = y_in * y_in;
    assign x_sq   = x_sq_s;
    assign y_sq   = y_sq_s;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign has_room      = count_reg < CW'(MAX_POINTS);
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // magnitudes of the coordinate sums
    assign sx_mag = sum_x_reg[SW-1] ? SW'(-sum_x_reg) : SW'(sum_x_reg);
    assign sy_mag = sum_y_reg[SW-1] ? SW'(-sum_y_reg) : SW'(sum_y_reg);

    // next candidate of r*n with the current bit set
    assign u_cand = rn_reg + (UW'(count_reg) << bit_reg);

    // multiplier operand select
    assign mul_start = (state_reg == ST_PROD_START) || (state_reg == ST_SQ_START);

    always_comb
    begin
        mul_a = MA'(u_cand);
        mul_b = u_cand;
        if (state_reg != ST_SQ_START)
        begin
            case (prod_sel_reg)
                PS_XX:
                begin
                    mul_a = sxx_reg;
                    mul_b = MB'(count_reg);
                end
                PS_YY:
                begin
                    mul_a = syy_reg;
                    mul_b = MB'(count_reg);
                end
                PS_SX:
                begin
                    mul_a = MA'(sx_mag);
                    mul_b = MB'(sx_mag);
                end
                default:
                begin
                    mul_a = MA'(sy_mag);
                    mul_b = MB'(sy_mag);
                end
            endcase
        end
    end

    rog_mul #(
        .MA (MA),
        .MB (MB)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // sequencer and accumulators
    always_comb
    begin
        state_next     = state_reg;
        prod_sel_next  = prod_sel_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sxx_next       = sxx_reg;
        syy_next       = syy_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        rn_next        = rn_reg;
        bit_next       = bit_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        sum_x_next = sum_x_reg + SW'(x_in);
                        sum_y_next = sum_y_reg + SW'(y_in);
                        sxx_next   = sxx_reg + QW'(x_sq);
                        syy_next   = syy_reg + QW'(y_sq);
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        prod_sel_next = PS_XX;
                        state_next    = ST_PROD_START;
                    end
                end
            end
            ST_PROD_START:
            begin
                state_next = ST_PROD_WAIT;
            end
            ST_PROD_WAIT:
            begin
                if (mul_done)
                begin
                    // build n*Sxx + n*Syy - Sx^2 - Sy^2
                    case (prod_sel_reg)
                        PS_XX:   d_next = mul_p;
                        PS_YY:   d_next = d_reg + mul_p;
                        default: d_next = d_reg - mul_p;
                    endcase
                    if (prod_sel_reg == PS_SY)
                    begin
                        r_next     = '0;
                        rn_next    = '0;
                        bit_next   = BIT_W'(RW - 1);
                        state_next = ST_SQ_START;
                    end
                    else
                    begin
                        prod_sel_next = prod_sel_reg + 2'd1;
                        state_next    = ST_PROD_START;
                    end
                end
            end
            ST_SQ_START:
            begin
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    // keep the bit when (r*n)^2 still fits under the variance sum
                    if (mul_p <= d_reg)
                    begin
                        r_next  = r_reg | (RW'(1) << bit_reg);
                        rn_next = u_cand;
                    end
                    if (bit_reg == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = ST_SQ_START;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_data_next  = {{OUT_PAD_W{1'b0}}, dropped_reg,
                                      POINTS_W'(count_reg), RADIUS_W'(r_reg)};
                    out_valid_next = 1'b1;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    sxx_next       = '0;
                    syy_next       = '0;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prod_sel_reg  <= PS_XX;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sxx_reg       <= '0;
            syy_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_sel_reg  <= prod_sel_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sxx_reg       <= sxx_next;
            syy_reg       <= syy_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // search datapath and output beat
    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        r_reg        <= r_next;
        rn_reg       <= rn_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_PROD_WAIT || state_reg == ST_SQ_WAIT))
        else $error("multiplier finished outside a wait state");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (count_reg == '0 && !dropped_reg && state_reg == ST_IDLE
                      && m_axis_tvalid))
        else $error("accumulators not cleared after result");

    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (state_reg == ST_PROD_START
                                       && prod_sel_reg == PS_XX))
        else $error("last point did not start the variance products");
`endif

endmodule

// File: bench/tb_radius_of_gyration_2d.sv
// self-checking bench for radius_of_gyration_2d: directed table, extreme path, random paths
// predicts each result in exact wide integer math; depends on rog_pkg and the rtl
module tb_radius_of_gyration_2d;
    import rog_pkg::*;

    localparam int MAX_POINTS   = 4096;
    localparam int COORD_BITS   = 16;
    localparam int IN_DATA_W    = ((2*COORD_BITS+7)/8)*8;
    localparam int RANDOM_ITEMS = 770;
    localparam int EXTREME_POINTS = 64;
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int SETTLE_CYCLES = 800;

    // result beat layout, lowest field last
    typedef struct packed {
        logic                overflowed;
        logic [POINTS_W-1:0] points_used;
        logic [RADIUS_W-1:0] radius;
    } radius_beat_t;

    // expected value typed in by hand for a point, used when known on sight
    typedef struct packed {
        logic         known;
        radius_beat_t value;
    } known_beat_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        known_beat_t check;
    } point_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // path accumulators of the predictor
    longint      path_sum_x   = 0;
    longint      path_sum_y   = 0;
    longint      path_sum_xx  = 0;
    longint      path_sum_yy  = 0;
    int          path_points  = 0;
    logic        path_dropped = 1'b0;

    radius_beat_t expected_radii[$];
    known_beat_t  known_radii[$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    bit           sender_gaps;
    bit           receiver_stalls;

    // directed points: extremes, single points, identical points, bit patterns
    point_row_t directed_rows [0:14] = '{
        '{16'h0000, 16'h0000, 1'b1, '{1'b1, '{1'b0, 13'd1, 16'd0}}},
        '{16'h7fff, 16'h8000, 1'b1, '{1'b1, '{1'b0, 13'd1, 16'd0}}},
        '{16'h8000, 16'h8000, 1'b0, '{1'b0, '0}},
        '{16'h7fff, 16'h7fff, 1'b1, '{1'b0, '0}},
        '{16'h8000, 16'h7fff, 1'b0, '{1'b0, '0}},
        '{16'h7fff, 16'h8000, 1'b1, '{1'b0, '0}},
        '{16'h0064, 16'hff9c, 1'b0, '{1'b0, '0}},
        '{16'h0064, 16'hff9c, 1'b0, '{1'b0, '0}},
        '{16'h0064, 16'hff9c, 1'b1, '{1'b1, '{1'b0, 13'd3, 16'd0}}},
        '{16'h0010, 16'h0000, 1'b0, '{1'b0, '0}},
        '{16'hfff0, 16'h0000, 1'b1, '{1'b1, '{1'b0, 13'd2, 16'd16}}},
        '{16'h5555, 16'haaaa, 1'b0, '{1'b0, '0}},
        '{16'haaaa, 16'h5555, 1'b0, '{1'b0, '0}},
        '{16'hffff, 16'h0001, 1'b0, '{1'b0, '0}},
        '{16'h0001, 16'hffff, 1'b1, '{1'b0, '0}}
    };

    radius_of_gyration_2d #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    // accumulate one point; on the last point return the floored radius and clear
    function automatic bit gyration_step(input logic signed [15:0] x,
                                         input logic signed [15:0] y,
                                         input logic last,
                                         output radius_beat_t beat);
        logic signed [127:0] wide_n;
        logic signed [127:0] wide_sx;
        logic signed [127:0] wide_sy;
        logic signed [127:0] wide_sxx;
        logic signed [127:0] wide_syy;
        logic signed [127:0] spread;
        logic signed [127:0] trial;
        logic signed [127:0] trial_sq;
        logic [17:0]         root;
        int                  bit_pos;
        beat = '0;
        if (path_points < MAX_POINTS)
        begin
            path_sum_x  += longint'(x);
            path_sum_y  += longint'(y);
            path_sum_xx += longint'(x) * longint'(x);
            path_sum_yy += longint'(y) * longint'(y);
            path_points++;
        end
        else
        begin
            path_dropped = 1'b1;
        end
        if (!last)
            return 1'b0;

        // n*Sxx - Sx^2 + n*Syy - Sy^2, never negative
        wide_n   = path_points;
        wide_sx  = path_sum_x;
        wide_sy  = path_sum_y;
        wide_sxx = path_sum_xx;
        wide_syy = path_sum_yy;
        spread   = wide_n * wide_sxx + wide_n * wide_syy - wide_sx * wide_sx - wide_sy * wide_sy;

        // largest r with (r*n)^2 <= spread, one bit at a time
        root = '0;
        for (bit_pos = COORD_BITS + 1; bit_pos >= 0; bit_pos--)
        begin
            trial    = {110'd0, root} | (128'd1 << bit_pos);
            trial_sq = (trial * wide_n) * (trial * wide_n);
            if (trial_sq <= spread)
                root = trial[17:0];
        end

        beat.radius      = root[RADIUS_W-1:0];
        beat.points_used = path_points[POINTS_W-1:0];
        beat.overflowed  = path_dropped;
        path_sum_x   = 0;
        path_sum_y   = 0;
        path_sum_xx  = 0;
        path_sum_yy  = 0;
        path_points  = 0;
        path_dropped = 1'b0;
        return 1'b1;
    endfunction

    // send one point beat, with an optional gap before it
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last,
                              input known_beat_t check);
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        known_radii = {known_radii, check};
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // drop valid and hold the sender until every pending result has come out
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_radii.size() != 0)
            @(negedge clk);
    endtask

    // check result beats, predict from accepted point beats
    always @(posedge clk)
    begin
        radius_beat_t got;
        radius_beat_t want;
        radius_beat_t predicted;
        known_beat_t  check;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RADIUS_W+POINTS_W:0];
                if (expected_radii.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %h", $time,
                             m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_radii.pop_front();
                    if (got.radius !== want.radius)
                    begin
                        $display("%0t: gyration_radius expected %0d actual %0d", $time,
                                 want.radius, got.radius);
                        mismatches++;
                    end
                    if (got.points_used !== want.points_used)
                    begin
                        $display("%0t: points_used expected %0d actual %0d", $time,
                                 want.points_used, got.points_used);
                        mismatches++;
                    end
                    if (got.overflowed !== want.overflowed)
                    begin
                        $display("%0t: overflowed expected %0d actual %0d", $time,
                                 want.overflowed, got.overflowed);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                check = known_radii.pop_front();
                if (gyration_step(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast,
                                  predicted))
                begin
                    if (check.known)
                        predicted = check.value;
                    expected_radii = {expected_radii, predicted};
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: ready high, with random stalls when enabled
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= 1'b1;
            if (receiver_stalls)
            begin
                stall = idle_len();
                repeat (stall)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int          i;
        int          k;
        int          len;
        int          pattern;
        int          random_items;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] mask;
        logic [15:0] x;
        logic [15:0] y;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (i = 0; i < $size(directed_rows); i++)
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                       directed_rows[i].check);
        drain_results();

        // path of alternating extremes: largest radius
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        for (i = 0; i < EXTREME_POINTS; i++)
            send_point(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff,
                       i == EXTREME_POINTS - 1, '0);
        drain_results();

        // random paths: mostly short, a few long
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(31, 150)
                                               : $urandom_range(1, 30);
            if (len > RANDOM_ITEMS - random_items)
                len = RANDOM_ITEMS - random_items;
            pattern         = $urandom_range(0, 3);
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            px   = 16'($urandom);
            py   = 16'($urandom);
            mask = 16'((32'd1 << $urandom_range(0, 15)) - 1);
            for (k = 0; k < len; k++)
            begin
                case (pattern)
                    // anywhere in range
                    0:
                    begin
                        x = 16'($urandom);
                        y = 16'($urandom);
                    end
                    // random walk with small steps
                    1:
                    begin
                        px = px + 16'($urandom_range(0, 64)) - 16'd32;
                        py = py + 16'($urandom_range(0, 64)) - 16'd32;
                        x  = px;
                        y  = py;
                    end
                    // extremes and near zero
                    2:
                    begin
                        x = pick_extreme();
                        y = pick_extreme();
                    end
                    // cluster of random spread around a center
                    default:
                    begin
                        x = px + (16'($urandom) & mask) - (mask >> 1);
                        y = py + (16'($urandom) & mask) - (mask >> 1);
                    end
                endcase
                send_point(x, y, k == len - 1, '0);
            end
            random_items += len;
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        // wind down
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_radii.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rog_pkg.sv
rtl/core/rog_mul.sv
rtl/core/radius_of_gyration_2d.sv
bench/tb_radius_of_gyration_2d.sv
